// ===== hdl/dsdd_pkg.sv =====
`default_nettype none

package dsdd_pkg;

   localparam int unsigned DAY_NUM_W = 22;
   localparam int unsigned YEAR_W    = 14;

   localparam logic [7:0] DASH_CHAR  = 8'h2D;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   localparam logic [YEAR_W-1:0] DAYS_PER_YEAR = 14'd365;
   // u / 100 == (u * DIV100_MULT) >> DIV100_SHIFT for every u below 43690.
   localparam logic [12:0] DIV100_MULT  = 13'd5243;
   localparam int unsigned DIV100_SHIFT = 19;

   localparam logic [3:0] MONTH_FEB = 4'd2;

   // The characters of one DD-MM-YYYY date.
   typedef struct packed {
      logic [15:0] day_chars;
      logic [7:0]  sep_one;
      logic [15:0] month_chars;
      logic [7:0]  sep_two;
      logic [31:0] year_chars;
   } date_chars_type;

   // Day number of one date and whether the date was well formed.
   typedef struct packed {
      logic                 valid;
      logic [DAY_NUM_W-1:0] number;
   } date_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
   endfunction

   // A character that is not a digit decodes as zero.
   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      d = c - DIGIT_ZERO;
      return is_digit(c) ? d[3:0] : 4'd0;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      case (month)
         4'd1:    return 9'd0;
         4'd2:    return 9'd31;
         4'd3:    return 9'd59;
         4'd4:    return 9'd90;
         4'd5:    return 9'd120;
         4'd6:    return 9'd151;
         4'd7:    return 9'd181;
         4'd8:    return 9'd212;
         4'd9:    return 9'd243;
         4'd10:   return 9'd273;
         4'd11:   return 9'd304;
         4'd12:   return 9'd334;
         default: return 9'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dsdd_date_unit.sv =====
`default_nettype none

// Two pipeline stages for one date: decode and check the text, then form
// the day number.
module dsdd_date_unit (
   input  wire logic                     clock,
   input  wire dsdd_pkg::date_chars_type chars,
   output dsdd_pkg::date_result_type     result
);

   typedef struct packed {
      logic                          valid;
      logic [6:0]                    day;
      logic [3:0]                    month;
      logic [dsdd_pkg::YEAR_W-1:0]   year;
   } decoded_type;

   decoded_type dec_in, dec_ff;
   dsdd_pkg::date_result_type result_in, result_ff;

   logic        digits_ok;
   logic [6:0]  month_full;
   logic [dsdd_pkg::YEAR_W-1:0] year_dec;

   always_comb begin
      digits_ok = dsdd_pkg::is_digit(chars.day_chars[15:8])
                & dsdd_pkg::is_digit(chars.day_chars[7:0])
                & dsdd_pkg::is_digit(chars.month_chars[15:8])
                & dsdd_pkg::is_digit(chars.month_chars[7:0])
                & dsdd_pkg::is_digit(chars.year_chars[31:24])
                & dsdd_pkg::is_digit(chars.year_chars[23:16])
                & dsdd_pkg::is_digit(chars.year_chars[15:8])
                & dsdd_pkg::is_digit(chars.year_chars[7:0]);

      month_full = 7'(dsdd_pkg::digit_value(chars.month_chars[15:8])) * 7'd10
                 + 7'(dsdd_pkg::digit_value(chars.month_chars[7:0]));

      year_dec = 14'(dsdd_pkg::digit_value(chars.year_chars[31:24])) * 14'd1000
               + 14'(dsdd_pkg::digit_value(chars.year_chars[23:16])) * 14'd100
               + 14'(dsdd_pkg::digit_value(chars.year_chars[15:8])) * 14'd10
               + 14'(dsdd_pkg::digit_value(chars.year_chars[7:0]));

      dec_in.valid = digits_ok
                   && (chars.sep_one == dsdd_pkg::DASH_CHAR)
                   && (chars.sep_two == dsdd_pkg::DASH_CHAR)
                   && (month_full >= 7'd1) && (month_full <= 7'd12);
      dec_in.day   = 7'(dsdd_pkg::digit_value(chars.day_chars[15:8])) * 7'd10
                   + 7'(dsdd_pkg::digit_value(chars.day_chars[7:0]));
      dec_in.month = month_full[3:0];
      dec_in.year  = year_dec;
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

   logic [dsdd_pkg::YEAR_W-1:0] leap_year;
   logic [26:0] div_prod;
   logic [6:0]  centuries;
   logic [11:0] leap_days;
   logic [27:0] year_days;

   always_comb begin
      // January and February count the leap days of the years before.
      if ((dec_ff.month <= dsdd_pkg::MONTH_FEB) && (dec_ff.year != '0)) begin
         leap_year = dec_ff.year - 14'd1;
      end else begin
         leap_year = dec_ff.year;
      end
      div_prod  = 27'(leap_year) * 27'(dsdd_pkg::DIV100_MULT);
      centuries = div_prod[dsdd_pkg::DIV100_SHIFT+6:dsdd_pkg::DIV100_SHIFT];
      // Year zero before March still gives zero, since 0/4 - 0/100 + 0/400 is 0.
      leap_days = 12'(leap_year[dsdd_pkg::YEAR_W-1:2]) - 12'(centuries)
                + 12'(centuries[6:2]);
      year_days = 28'(dec_ff.year) * 28'(dsdd_pkg::DAYS_PER_YEAR);

      result_in.valid  = dec_ff.valid;
      result_in.number = year_days[dsdd_pkg::DAY_NUM_W-1:0]
                       + 22'(dec_ff.day)
                       + 22'(dsdd_pkg::days_before_month(dec_ff.month))
                       + 22'(leap_days);
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== hdl/date_string_day_difference.sv =====
`default_nettype none

// Day difference between two DD-MM-YYYY dates in ASCII. Each date is
// checked (digits in every digit place, '-' in both separator places,
// month 01..12; the day is not range checked) and turned into a day number,
// and the absolute difference of the two is returned, or zero when either
// date is malformed. A word is accepted on every clock edge with start high;
// busy is never raised. Its result is shown for exactly one cycle with
// rsp_valid high, after the input register, the decode stage, the day
// number stage and the result register. The receiver cannot stall
// the block, so it must take every result word in the cycle it is shown.
module date_string_day_difference (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [15:0] req_first_day_chars,
   input  wire logic [7:0]  req_first_sep_one,
   input  wire logic [15:0] req_first_month_chars,
   input  wire logic [7:0]  req_first_sep_two,
   input  wire logic [31:0] req_first_year_chars,
   input  wire logic [15:0] req_second_day_chars,
   input  wire logic [7:0]  req_second_sep_one,
   input  wire logic [15:0] req_second_month_chars,
   input  wire logic [7:0]  req_second_sep_two,
   input  wire logic [31:0] req_second_year_chars,
   output      logic        rsp_valid,
   output      logic [21:0] rsp_day_difference,
   output      logic        rsp_first_valid,
   output      logic        rsp_second_valid
);

   // The pipeline never holds a word back, so there is nothing to wait for.
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Strobe pipeline: one bit follows each word through the stages.
   logic in_vld_ff, dec_vld_ff, num_vld_ff, rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         dec_vld_ff <= 1'b0;
         num_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= accept;
         dec_vld_ff <= in_vld_ff;
         num_vld_ff <= dec_vld_ff;
         rsp_vld_ff <= num_vld_ff;
      end
   end

   // Input register. Payload is captured whenever a word is accepted.
   dsdd_pkg::date_chars_type first_ff, second_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff.day_chars    <= req_first_day_chars;
         first_ff.sep_one      <= req_first_sep_one;
         first_ff.month_chars  <= req_first_month_chars;
         first_ff.sep_two      <= req_first_sep_two;
         first_ff.year_chars   <= req_first_year_chars;
         second_ff.day_chars   <= req_second_day_chars;
         second_ff.sep_one     <= req_second_sep_one;
         second_ff.month_chars <= req_second_month_chars;
         second_ff.sep_two     <= req_second_sep_two;
         second_ff.year_chars  <= req_second_year_chars;
      end
   end

   // One decode and day number unit per date, running side by side.
   dsdd_pkg::date_result_type first_num, second_num;

   dsdd_date_unit u_first (
      .clock  (clock),
      .chars  (first_ff),
      .result (first_num)
   );

   dsdd_date_unit u_second (
      .clock  (clock),
      .chars  (second_ff),
      .result (second_num)
   );

   // Result stage: absolute difference, forced to zero for a bad date.
   logic [21:0] diff_in, diff_ff;
   logic        first_valid_ff, second_valid_ff;

   always_comb begin
      if (!(first_num.valid && second_num.valid)) begin
         diff_in = '0;
      end else if (second_num.number > first_num.number) begin
         diff_in = second_num.number - first_num.number;
      end else begin
         diff_in = first_num.number - second_num.number;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff         <= diff_in;
      first_valid_ff  <= first_num.valid;
      second_valid_ff <= second_num.valid;
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_day_difference = diff_ff;
   assign rsp_first_valid    = first_valid_ff;
   assign rsp_second_valid   = second_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/dsdd_checker.sv =====
`default_nettype none

module dsdd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [21:0] rsp_day_difference,
   input wire logic        rsp_first_valid,
   input wire logic        rsp_second_valid
);

   // Counts clean cycles since reset so that the latency check only looks
   // back over cycles in which the pipeline was running.
   logic [2:0] clean_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clean_ff <= '0;
      end else if (clean_ff != 3'd5) begin
         clean_ff <= clean_ff + 3'd1;
      end
   end

   // Every accepted word yields exactly one result word, and no result word comes without one.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (clean_ff == 3'd5) |-> (rsp_valid == $past(start && !busy, 4)))
      else $error("result strobe does not match accepted word");

   a_strobe_after_reset: assert property (@(posedge clock) disable iff (reset)
      (clean_ff < 3'd4) |-> !rsp_valid)
      else $error("result strobe without accepted word after reset");

   a_first_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_first_valid) |-> (rsp_day_difference == '0))
      else $error("nonzero difference with malformed first date");

   a_second_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_second_valid) |-> (rsp_day_difference == '0))
      else $error("nonzero difference with malformed second date");

endmodule

bind date_string_day_difference dsdd_checker u_dsdd_checker (.*);

`default_nettype wire
